FILE: rtl/core/iss_pkg.sv
// Shared types, constants and helpers for the integer insertion sorter.
// No dependencies; every other file of the sorter uses this package.
`timescale 1ns / 1ps

package iss_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned DW    = 32;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  // readout is a two-level selection: LANES cells per group, NGRP groups
  localparam int unsigned LANES = 32;
  localparam int unsigned LW    = $clog2(LANES);
  localparam int unsigned NGRP  = (DEPTH + LANES - 1) / LANES;
  localparam int unsigned GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned XW    = LW + GW;

  typedef logic [DW-1:0] data_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [XW-1:0] idx_t;
  typedef logic [LW-1:0] lane_t;
  typedef logic [GW-1:0] grp_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_TAKE   = 1'b1
  } mode_e;

  typedef enum logic {
    STAT_OK    = 1'b0,
    STAT_EMPTY = 1'b1
  } status_e;

  // what one cell shows its right-hand neighbour
  typedef struct packed {
    data_t val;
    logic  gt;
    logic  occ;
  } link_t;

  function automatic logic gt_signed(input data_t a, input data_t b);
    gt_signed = $signed(a) > $signed(b);
  endfunction

endpackage

FILE: rtl/core/iss_if.sv
// Valid/ready channel interfaces for the sorter: item in, result out.
// Depends on iss_pkg.
`timescale 1ns / 1ps

interface iss_item_if;
  logic           valid;
  logic           ready;
  logic           mode;
  iss_pkg::data_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface iss_res_if;
  logic           valid;
  logic           ready;
  iss_pkg::data_t sorted_value;
  logic           last;
  logic           status;
  logic           overflowed;

  modport source (output valid, output sorted_value, output last, output status,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last, input status,
                  input overflowed, output ready);
endinterface

FILE: rtl/core/iss_cell.sv
// One cell of the insertion chain: holds one sorted entry and shifts up.
// Depends on iss_pkg.
`timescale 1ns / 1ps

module iss_cell (
  input  logic           clk_i,
  input  logic           ins_i,
  input  iss_pkg::data_t ins_val_i,
  input  logic           occ_i,
  input  iss_pkg::link_t left_i,
  output iss_pkg::link_t cell_o
);

  iss_pkg::data_t val_q;
  iss_pkg::data_t val_d;
  logic           own_gt;
  logic           first_free;
  logic           wr_en;

  assign own_gt     = occ_i & iss_pkg::gt_signed(val_q, ins_val_i);
  assign first_free = ~occ_i & left_i.occ;
  assign wr_en      = ins_i & (own_gt | first_free);
  // take the neighbour's entry if it moves up, else the new value lands here
  assign val_d      = left_i.gt ? left_i.val : ins_val_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      val_q <= val_d;
    end
  end

  assign cell_o = '{val: val_q, gt: own_gt, occ: occ_i};

endmodule

FILE: rtl/core/iss_rd.sv
// Registered two-level readout of the cell chain at the take pointer.
// Depends on iss_pkg.
`timescale 1ns / 1ps

module iss_rd (
  input  logic           clk_i,
  input  logic           ld_i,
  input  iss_pkg::data_t cells_i [iss_pkg::DEPTH],
  input  iss_pkg::idx_t  idx_i,
  output iss_pkg::data_t val_o
);

  iss_pkg::data_t pad   [iss_pkg::NGRP][iss_pkg::LANES];
  iss_pkg::data_t grp_d [iss_pkg::NGRP];
  iss_pkg::data_t grp_q [iss_pkg::NGRP];
  iss_pkg::grp_t  hi_q;
  iss_pkg::lane_t lo;

  assign lo = idx_i[iss_pkg::LW-1:0];

  always_comb begin
    for (int g = 0; g < iss_pkg::NGRP; g++) begin
      for (int l = 0; l < iss_pkg::LANES; l++) begin
        if (g * iss_pkg::LANES + l < iss_pkg::DEPTH) begin
          pad[g][l] = cells_i[g * iss_pkg::LANES + l];
        end else begin
          pad[g][l] = '0;
        end
      end
    end
    for (int g = 0; g < iss_pkg::NGRP; g++) begin
      grp_d[g] = pad[g][lo];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      grp_q <= grp_d;
      hi_q  <= idx_i[iss_pkg::XW-1:iss_pkg::LW];
    end
  end

  assign val_o = grp_q[hi_q];

endmodule

FILE: rtl/core/integer_insertion_sorter_core.sv
// Top level of the integer insertion sorter: cell chain, readout, control.
// Depends on iss_pkg, iss_if, iss_cell and iss_rd.
//
//   channel  | dir | beat                                       | accepted when
//   item_i   | in  | mode, value                                | valid & ready
//   res_o    | out | sorted_value, last, status, overflowed     | valid & ready
//
// Inserts: one beat per cycle while item_i.ready is high; every cell compares in parallel and shifts.
// Takes: registered group select, then final select into the result register.
// item_i.ready drops only while a take waits behind a stalled result.
// Reset clears count, pointer, flag and valids; cell contents are not reset.
`timescale 1ns / 1ps

module integer_insertion_sorter_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  iss_item_if.sink        item_i,
  iss_res_if.source       res_o
);

  iss_pkg::cnt_t  cnt_q, cnt_d;
  iss_pkg::cnt_t  ptr_q, ptr_d;
  iss_pkg::cnt_t  ptr_nxt;
  logic           ovf_q, ovf_d;

  logic           s1_v_q;
  logic           s1_last_q;
  logic           s1_empty_q;
  logic           s1_ovf_q;
  logic           s1_adv;

  logic           res_v_q;
  iss_pkg::data_t res_val_q;
  logic           res_last_q;
  logic           res_stat_q;
  logic           res_ovf_q;

  logic           acc;
  logic           ins_acc;
  logic           take_acc;
  logic           full;
  logic           has_item;
  logic           is_last;

  logic           occ      [iss_pkg::DEPTH];
  iss_pkg::link_t lnk      [iss_pkg::DEPTH];
  iss_pkg::data_t cell_val [iss_pkg::DEPTH];
  iss_pkg::data_t rd_val;

  assign s1_adv   = s1_v_q & (~res_v_q | res_o.ready);
  assign item_i.ready = ~s1_v_q | s1_adv;
  assign acc      = item_i.valid & item_i.ready;
  assign ins_acc  = acc & (item_i.mode == iss_pkg::MODE_INSERT);
  assign take_acc = acc & (item_i.mode == iss_pkg::MODE_TAKE);

  assign full     = cnt_q == iss_pkg::cnt_t'(iss_pkg::DEPTH);
  assign has_item = ptr_q < cnt_q;
  assign ptr_nxt  = ptr_q + iss_pkg::cnt_t'(1);
  assign is_last  = ptr_nxt == cnt_q;

  // cell chain
  for (genvar i = 0; i < iss_pkg::DEPTH; i++) begin : g_cell
    assign occ[i] = iss_pkg::cnt_t'(i) < cnt_q;
    if (i == 0) begin : g_head
      iss_cell u_cell (
        .clk_i     (clk_i),
        .ins_i     (ins_acc & ~full),
        .ins_val_i (item_i.value),
        .occ_i     (occ[i]),
        .left_i    ('{val: '0, gt: 1'b0, occ: 1'b1}),
        .cell_o    (lnk[i])
      );
    end else begin : g_body
      iss_cell u_cell (
        .clk_i     (clk_i),
        .ins_i     (ins_acc & ~full),
        .ins_val_i (item_i.value),
        .occ_i     (occ[i]),
        .left_i    (lnk[i-1]),
        .cell_o    (lnk[i])
      );
    end
    assign cell_val[i] = lnk[i].val;
  end

  iss_rd u_rd (
    .clk_i   (clk_i),
    .ld_i    (take_acc),
    .cells_i (cell_val),
    .idx_i   (iss_pkg::idx_t'(ptr_q)),
    .val_o   (rd_val)
  );

  always_comb begin
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    ovf_d = ovf_q;
    if (ins_acc) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + iss_pkg::cnt_t'(1);
      end
    end else if (take_acc && has_item) begin
      if (is_last) begin
        cnt_d = '0;
        ptr_d = '0;
        ovf_d = 1'b0;
      end else begin
        ptr_d = ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ptr_q   <= '0;
      ovf_q   <= 1'b0;
      s1_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      ovf_q <= ovf_d;
      if (take_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        res_v_q <= 1'b1;
      end else if (res_o.ready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_acc) begin
      s1_last_q  <= has_item & is_last;
      s1_empty_q <= ~has_item;
      s1_ovf_q   <= ovf_q;
    end
    if (s1_adv) begin
      res_val_q  <= s1_empty_q ? '0 : rd_val;
      res_last_q <= s1_last_q;
      res_stat_q <= s1_empty_q ? iss_pkg::STAT_EMPTY : iss_pkg::STAT_OK;
      res_ovf_q  <= s1_ovf_q;
    end
  end

  assign res_o.valid        = res_v_q;
  assign res_o.sorted_value = res_val_q;
  assign res_o.last         = res_last_q;
  assign res_o.status       = res_stat_q;
  assign res_o.overflowed   = res_ovf_q;

endmodule

FILE: rtl/core/iss_chk.sv
// Port-level checker for the integer insertion sorter, bound to the top.
// Depends on iss_pkg and integer_insertion_sorter_core.
`timescale 1ns / 1ps

module iss_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           in_mode_i,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input iss_pkg::data_t res_value_i,
  input logic           res_last_i,
  input logic           res_status_i
);

  logic take_acc;

  assign take_acc = in_valid_i & in_ready_i & (in_mode_i == iss_pkg::MODE_TAKE);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_value_i)
      && $stable(res_last_i) && $stable(res_status_i))
    else $error("result beat changed while stalled");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == iss_pkg::STAT_EMPTY |-> res_value_i == '0 && !res_last_i)
    else $error("empty result carries value or last");

  a_take_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_acc |-> ##2 res_valid_i)
    else $error("take beat produced no result in time");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(take_acc, 2))
    else $error("result appeared without a take");

endmodule

bind integer_insertion_sorter_core iss_chk u_iss_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .in_mode_i    (item_i.mode),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_value_i  (res_o.sorted_value),
  .res_last_i   (res_o.last),
  .res_status_i (res_o.status)
);

FILE: tb/tb_top.sv
// Self-checking bench for integer_insertion_sorter_core: random and directed
// insert/take beats, predicted results compared field by field on res_o.
// Depends on iss_pkg, iss_if and the sorter RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned CHOKE_LEN   = 300;

  typedef struct {
    iss_pkg::mode_e mode;
    iss_pkg::data_t value;
    bit             rush;
    bit             drain;
    bit             choke;
  } beat_t;

  typedef struct {
    iss_pkg::data_t   value;
    logic             last;
    iss_pkg::status_e status;
    logic             ovf;
  } sorted_t;

  logic           clk_i   = 1'b0;
  logic           rst_ni  = 1'b0;
  logic           drv_valid = 1'b0;
  logic           drv_mode  = 1'b0;
  iss_pkg::data_t drv_value = '0;
  logic           rx_ready  = 1'b0;

  iss_item_if item_if ();
  iss_res_if  res_if ();

  assign item_if.valid = drv_valid;
  assign item_if.mode  = drv_mode;
  assign item_if.value = drv_value;
  assign res_if.ready  = rx_ready;

  integer_insertion_sorter_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .res_o  (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // beats still to send, results still owed
  beat_t   beat_q[$];
  sorted_t due_q[$];

  // shadow of the sorted store
  iss_pkg::data_t shadow_store[iss_pkg::DEPTH];
  int unsigned    shadow_cnt = 0;
  int unsigned    shadow_ptr = 0;
  logic           shadow_ovf = 1'b0;

  // occupancy as the stimulus sees it, used only to plan whole sets
  int unsigned plan_cnt = 0;
  int unsigned plan_ptr = 0;
  int unsigned n_planned = 0;

  int unsigned n_ins = 0, n_drop = 0, n_take = 0, n_empty = 0, n_sets = 0;
  int unsigned n_res = 0, n_err = 0;

  bit choke_req = 1'b0;

  function automatic int unsigned draw_gap(inout int unsigned seg_left,
                                           inout bit seg_busy);
    if (seg_left == 0) begin
      seg_left = $urandom_range(10, 80);
      seg_busy = ($urandom_range(0, 2) != 0);
    end
    seg_left--;
    return seg_busy ? $urandom_range(0, 15) : 0;
  endfunction

  function automatic iss_pkg::data_t pick_value();
    case ($urandom_range(0, 7))
      0: begin
        return 32'h7FFF_FFFF;
      end
      1: begin
        return 32'h8000_0000;
      end
      2: begin
        return iss_pkg::data_t'($urandom_range(0, 8)) - 32'd4;
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  task automatic sort_step(input iss_pkg::mode_e m, input iss_pkg::data_t v);
    sorted_t     r;
    int unsigned pos;
    if (m == iss_pkg::MODE_INSERT) begin
      n_ins++;
      if (shadow_cnt >= iss_pkg::DEPTH) begin
        shadow_ovf = 1'b1;
        n_drop++;
      end else begin
        pos = shadow_cnt;
        while (pos > 0 && $signed(shadow_store[pos-1]) > $signed(v)) begin
          shadow_store[pos] = shadow_store[pos-1];
          pos--;
        end
        shadow_store[pos] = v;
        shadow_cnt++;
      end
    end else begin
      n_take++;
      r.ovf = shadow_ovf;
      if (shadow_ptr >= shadow_cnt) begin
        r.value  = '0;
        r.last   = 1'b0;
        r.status = iss_pkg::STAT_EMPTY;
        n_empty++;
      end else begin
        r.value  = shadow_store[shadow_ptr];
        r.status = iss_pkg::STAT_OK;
        shadow_ptr++;
        r.last = (shadow_ptr >= shadow_cnt);
        if (r.last) begin
          shadow_cnt = 0;
          shadow_ptr = 0;
          shadow_ovf = 1'b0;
          n_sets++;
        end
      end
      due_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t ns: result %0d %s expected %h actual %h",
               $time, n_res, name, want, got);
    end
  endtask

  task automatic add_beat(input iss_pkg::mode_e m, input iss_pkg::data_t v,
                          input bit rush, input bit drain, input bit choke);
    beat_t b;
    b.mode  = m;
    b.value = v;
    b.rush  = rush;
    b.drain = drain;
    b.choke = choke;
    beat_q.push_back(b);
    n_planned++;
    if (m == iss_pkg::MODE_INSERT) begin
      if (plan_cnt < iss_pkg::DEPTH) plan_cnt++;
    end else if (plan_ptr < plan_cnt) begin
      plan_ptr++;
      if (plan_ptr == plan_cnt) begin
        plan_cnt = 0;
        plan_ptr = 0;
      end
    end
  endtask

  // n inserts, then takes to the end of the set with the odd late insert
  task automatic add_set(input int unsigned n, input bit rush, input bit drain,
                         input bit choke);
    for (int unsigned i = 0; i < n; i++)
      add_beat(iss_pkg::MODE_INSERT, pick_value(), rush, drain && i == 0,
               choke && i == 0);
    while (plan_cnt != 0)
      add_beat(($urandom_range(0, 9) == 0) ? iss_pkg::MODE_INSERT : iss_pkg::MODE_TAKE,
               pick_value(), rush, 1'b0, 1'b0);
  endtask

  // driver
  int unsigned tx_gap = 0, tx_seg = 0;
  bit          tx_busy = 1'b0;
  beat_t       cur;

  always @(posedge clk_i) begin
    bit take_new;
    take_new = 1'b0;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && item_if.ready) sort_step(cur.mode, cur.value);
      if (drv_valid && !item_if.ready) begin
        take_new = 1'b0;
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (beat_q.size() != 0 && !(beat_q[0].drain && due_q.size() != 0)) begin
        take_new = 1'b1;
      end
      if (take_new) begin
        cur = beat_q.pop_front();
        drv_mode  <= cur.mode;
        drv_value <= cur.value;
        tx_gap = cur.rush ? 0 : draw_gap(tx_seg, tx_busy);
        if (cur.choke) choke_req = 1'b1;
      end
      drv_valid <= take_new || (drv_valid && !item_if.ready);
    end
  end

  // monitor and result-side back-pressure
  int unsigned rx_wait = 0, rx_seg = 0, rx_hold = 0;
  bit          rx_busy = 1'b0, choke_done = 1'b0;

  always @(posedge clk_i) begin
    sorted_t w;
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else begin
      if (res_if.valid && rx_ready) begin
        if (due_q.size() == 0) begin
          n_err++;
          $display("%0t ns: result %0d unexpected, expected none actual %h/%b/%b/%b",
                   $time, n_res, res_if.sorted_value, res_if.last, res_if.status,
                   res_if.overflowed);
        end else begin
          w = due_q.pop_front();
          check_field("sorted_value", w.value, res_if.sorted_value);
          check_field("last", 32'(w.last), 32'(res_if.last));
          check_field("status", 32'(w.status), 32'(res_if.status));
          check_field("overflowed", 32'(w.ovf), 32'(res_if.overflowed));
        end
        n_res++;
        rx_wait = draw_gap(rx_seg, rx_busy);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (choke_req && !choke_done) begin
        choke_done = 1'b1;
        rx_hold = CHOKE_LEN;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      rx_ready <= (rx_wait == 0) && (rx_hold == 0);
    end
  end

  // watchdog
  int unsigned quiet = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $time, quiet);
        $display("FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    bit pressed;
    pressed = 1'b0;

    // empty take, extremes and duplicates, empty take after the set
    add_beat(iss_pkg::MODE_TAKE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_INSERT, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_INSERT, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_INSERT, 32'h0000_0001, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_INSERT, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    repeat (6) add_beat(iss_pkg::MODE_TAKE, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_TAKE, 32'h8000_0000, 1'b0, 1'b0, 1'b0);
    // insert below the take pointer mid read-out
    add_beat(iss_pkg::MODE_INSERT, 32'd5, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_INSERT, 32'd3, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_TAKE, 32'd0, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_INSERT, 32'd1, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_TAKE, 32'd0, 1'b0, 1'b0, 1'b0);
    add_beat(iss_pkg::MODE_TAKE, 32'd0, 1'b0, 1'b0, 1'b0);

    while (n_planned < 350) begin
      if (!pressed && n_planned > 150) begin
        // back-to-back set against a long result stall
        pressed = 1'b1;
        add_set(60, 1'b1, 1'b1, 1'b1);
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          add_beat(iss_pkg::mode_e'($urandom_range(0, 1)), pick_value(),
                   1'b0, 1'b0, 1'b0);
      end else begin
        add_set(($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                             : $urandom_range(1, 12),
                1'b0, 1'b0, 1'b0);
      end
    end
    // fill past the top so inserts are dropped, then take a few with the flag up
    for (int unsigned i = 0; i < iss_pkg::DEPTH + 2; i++)
      add_beat(iss_pkg::MODE_INSERT, pick_value(), 1'b0, i == 0, 1'b0);
    repeat (4) add_beat(iss_pkg::MODE_TAKE, 32'd0, 1'b0, 1'b0, 1'b0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (beat_q.size() != 0 || drv_valid || due_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d inserts (%0d dropped on a full store) and %0d takes (%0d empty).",
             n_ins, n_drop, n_take, n_empty);
    $display("Read out %0d complete sets; %0d results checked, %0d mismatches.",
             n_sets, n_res, n_err);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
